/* src/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every rising edge outside reset
`define BIS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property on every rising edge, reset included
`define BIS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/bis_pkg.sv */
`default_nettype none
package bis_pkg;

  localparam int MAX_WIDTH   = 512;
  localparam int MAX_HEIGHT  = 512;
  localparam int FRAC_BITS   = 16;

  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int HALF_W      = (MAX_WIDTH + 1) / 2;
  localparam int HALF_H      = (MAX_HEIGHT + 1) / 2;
  localparam int BANK_DEPTH  = HALF_W * HALF_H;
  localparam int BANK_AW     = $clog2(BANK_DEPTH);
  localparam int NUM_BANKS   = 4;

  localparam int SIZE_W      = 10;
  localparam int SCALE_W     = 24;
  localparam int COORD_W     = 12;
  localparam int CH_W        = 8;
  localparam int PIX_W       = 3 * CH_W;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = SCALE_W;

  localparam int P_W         = COORD_W + 1 + SCALE_W;
  localparam int IDX_W       = P_W - FRAC_BITS;
  localparam int OMF_W       = FRAC_BITS + 1;
  localparam int W_W         = 2 * FRAC_BITS + 1;
  localparam int PROD_W      = CH_W + W_W;
  localparam int SUM_W       = CH_W + 2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SOURCE_WIDTH  = 2'd0,
    REG_SOURCE_HEIGHT = 2'd1,
    REG_SCALE_X       = 2'd2,
    REG_SCALE_Y       = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    OP_LOAD    = 1'b0,
    OP_COMPUTE = 1'b1
  } op_t;

  typedef struct packed {
    logic [SIZE_W-1:0]  source_width;
    logic [SIZE_W-1:0]  source_height;
    logic [SCALE_W-1:0] scale_x;
    logic [SCALE_W-1:0] scale_y;
  } cfg_t;

  typedef struct packed {
    logic                 is_load;
    logic [COL_W-1:0]     x0;
    logic [COL_W-1:0]     x1;
    logic [ROW_W-1:0]     y0;
    logic [ROW_W-1:0]     y1;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;
    logic [PIX_W-1:0]     pixel;
  } work_t;

  function automatic int last_index(input logic [SIZE_W-1:0] v, input int maxv);
    int e;
    e = (v == '0) ? 1 : ((int'(v) > maxv) ? maxv : int'(v));
    return e - 1;
  endfunction

endpackage
`default_nettype wire

/* src/bis_ram.sv */
`default_nettype none
module bis_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* src/bis_front.sv */
`default_nettype none
module bis_front (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire bis_pkg::cfg_t                cfg,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         opcode,
  input  wire logic [bis_pkg::COORD_W-1:0]  x_coord,
  input  wire logic [bis_pkg::COORD_W-1:0]  y_coord,
  input  wire logic [bis_pkg::CH_W-1:0]     blue_in,
  input  wire logic [bis_pkg::CH_W-1:0]     green_in,
  input  wire logic [bis_pkg::CH_W-1:0]     red_in,
  input  wire logic                         q_full,
  output logic                              push,
  output bis_pkg::work_t                    push_item
);
  import bis_pkg::*;

  logic                 advance;
  logic                 f1_valid;
  logic                 f1_op;
  logic [COORD_W-1:0]   f1_x;
  logic [COORD_W-1:0]   f1_y;
  logic [PIX_W-1:0]     f1_pix;
  logic [P_W-1:0]       f1_px;
  logic [P_W-1:0]       f1_py;
  logic                 f2_valid;
  work_t                f2_item;
  logic                 keep;
  work_t                item_next;
  logic [P_W-1:0]       qx;
  logic [P_W-1:0]       qy;
  logic [IDX_W-1:0]     ip1x;
  logic [IDX_W-1:0]     ip1y;
  logic [IDX_W-1:0]     lox;
  logic [IDX_W-1:0]     loy;
  logic [IDX_W-1:0]     lastx;
  logic [IDX_W-1:0]     lasty;

  assign advance   = !f2_valid || !q_full;
  assign in_stall  = !advance;
  assign push      = f2_valid && !q_full;
  assign push_item = f2_item;

  always_comb begin
    qx    = P_W'(f1_px >> 1) + P_W'(1 << (FRAC_BITS - 1));
    qy    = P_W'(f1_py >> 1) + P_W'(1 << (FRAC_BITS - 1));
    ip1x  = qx[P_W-1:FRAC_BITS];
    ip1y  = qy[P_W-1:FRAC_BITS];
    lox   = (ip1x == '0) ? '0 : ip1x - IDX_W'(1);
    loy   = (ip1y == '0) ? '0 : ip1y - IDX_W'(1);
    lastx = IDX_W'(last_index(cfg.source_width, MAX_WIDTH));
    lasty = IDX_W'(last_index(cfg.source_height, MAX_HEIGHT));
    item_next.pixel = f1_pix;
    if (f1_op == OP_LOAD) begin
      keep              = (int'(f1_x) < MAX_WIDTH) && (int'(f1_y) < MAX_HEIGHT);
      item_next.is_load = 1'b1;
      item_next.x0      = f1_x[COL_W-1:0];
      item_next.x1      = f1_x[COL_W-1:0];
      item_next.y0      = f1_y[ROW_W-1:0];
      item_next.y1      = f1_y[ROW_W-1:0];
      item_next.fx      = '0;
      item_next.fy      = '0;
    end else begin
      keep              = 1'b1;
      item_next.is_load = 1'b0;
      item_next.x0      = COL_W'((lox > lastx) ? lastx : lox);
      item_next.x1      = COL_W'((ip1x > lastx) ? lastx : ip1x);
      item_next.y0      = ROW_W'((loy > lasty) ? lasty : loy);
      item_next.y1      = ROW_W'((ip1y > lasty) ? lasty : ip1y);
      item_next.fx      = qx[FRAC_BITS-1:0];
      item_next.fy      = qy[FRAC_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
      f2_valid <= 1'b0;
    end else if (advance) begin
      f1_valid <= in_valid;
      f2_valid <= f1_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      f1_op   <= opcode;
      f1_x    <= x_coord;
      f1_y    <= y_coord;
      f1_pix  <= {red_in, green_in, blue_in};
      f1_px   <= P_W'({x_coord, 1'b1}) * P_W'(cfg.scale_x);
      f1_py   <= P_W'({y_coord, 1'b1}) * P_W'(cfg.scale_y);
      f2_item <= item_next;
    end
  end

endmodule
`default_nettype wire

/* src/bis_queue.sv */
`default_nettype none
module bis_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire bis_pkg::work_t push_item,
  output logic                full,
  input  wire logic           pop,
  output bis_pkg::work_t      head,
  output logic                not_empty
);
  import bis_pkg::*;

  work_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;

  assign full      = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QPTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + QPTR_W'(1);
      end
      count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_item;
    end
  end

endmodule
`default_nettype wire

/* src/bis_back.sv */
`default_nettype none
module bis_back (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire bis_pkg::work_t           head,
  input  wire logic                     not_empty,
  output logic                          pop,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [bis_pkg::CH_W-1:0]      blue_out,
  output logic [bis_pkg::CH_W-1:0]      green_out,
  output logic [bis_pkg::CH_W-1:0]      red_out
);
  import bis_pkg::*;

  logic                 advance;
  logic [BANK_AW-1:0]   raddr [NUM_BANKS];
  logic [PIX_W-1:0]     rdata [NUM_BANKS];
  logic [NUM_BANKS-1:0] we;
  logic [BANK_AW-1:0]   waddr;
  logic [OMF_W-1:0]     omx;
  logic [OMF_W-1:0]     omy;
  logic [W_W-1:0]       w_next [4];
  logic [1:0]           sel_next [4];
  logic                 b1_valid;
  logic [W_W-1:0]       b1_w [4];
  logic [1:0]           b1_sel [4];
  logic                 b2_valid;
  logic [CH_W-1:0]      b2_term [3][4];
  logic [CH_W-1:0]      term_next [3][4];
  logic [CH_W-1:0]      res_next [3];

  assign advance = !out_valid || !out_stall;
  assign pop     = advance && not_empty;
  assign waddr   = BANK_AW'(int'(head.y0 >> 1) * HALF_W + int'(head.x0 >> 1));

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    assign col      = (head.x0[0] == b[0]) ? head.x0 : head.x1;
    assign row      = (head.y0[0] == b[1]) ? head.y0 : head.y1;
    assign raddr[b] = BANK_AW'(int'(row >> 1) * HALF_W + int'(col >> 1));
    assign we[b]    = pop && head.is_load && ({head.y0[0], head.x0[0]} == 2'(b));
    bis_ram #(
      .WIDTH (PIX_W),
      .DEPTH (BANK_DEPTH)
    ) u_ram (
      .clk   (clk),
      .we    (we[b]),
      .waddr (waddr),
      .wdata (head.pixel),
      .re    (advance),
      .raddr (raddr[b]),
      .rdata (rdata[b])
    );
  end

  always_comb begin
    omx = OMF_W'(1 << FRAC_BITS) - OMF_W'(head.fx);
    omy = OMF_W'(1 << FRAC_BITS) - OMF_W'(head.fy);
    w_next[0]   = W_W'(omx * omy);
    w_next[1]   = W_W'(OMF_W'(head.fx) * omy);
    w_next[2]   = W_W'(omx * OMF_W'(head.fy));
    w_next[3]   = W_W'(OMF_W'(head.fx) * OMF_W'(head.fy));
    sel_next[0] = {head.y0[0], head.x0[0]};
    sel_next[1] = {head.y0[0], head.x1[0]};
    sel_next[2] = {head.y1[0], head.x0[0]};
    sel_next[3] = {head.y1[0], head.x1[0]};
  end

  always_comb begin
    logic [PIX_W-1:0]  px;
    logic [PROD_W-1:0] prod;
    for (int k = 0; k < 4; k++) begin
      px = rdata[b1_sel[k]];
      for (int c = 0; c < 3; c++) begin
        prod = PROD_W'(px[c*CH_W +: CH_W]) * PROD_W'(b1_w[k])
             + PROD_W'(64'd1 << (2 * FRAC_BITS - 1));
        term_next[c][k] = prod[2*FRAC_BITS +: CH_W];
      end
    end
  end

  always_comb begin
    logic [SUM_W-1:0] sum;
    for (int c = 0; c < 3; c++) begin
      sum = SUM_W'(b2_term[c][0]) + SUM_W'(b2_term[c][1])
          + SUM_W'(b2_term[c][2]) + SUM_W'(b2_term[c][3]);
      res_next[c] = (sum > SUM_W'(255)) ? CH_W'(255) : sum[CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid  <= 1'b0;
      b2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      b1_valid  <= pop && !head.is_load;
      b2_valid  <= b1_valid;
      out_valid <= b2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      b1_w      <= w_next;
      b1_sel    <= sel_next;
      b2_term   <= term_next;
      blue_out  <= res_next[0];
      green_out <= res_next[1];
      red_out   <= res_next[2];
    end
  end

endmodule
`default_nettype wire

/* src/bilinear_image_scaler_top.sv */
`default_nettype none
// Bilinear image scaler, half-pixel mapping, 8-bit blue/green/red pixels.
// Load items (opcode 0) with coordinates inside the store write one source
// pixel into it and give no result; compute items (opcode 1) give one
// interpolated pixel each. One item is taken per clock when nothing
// downstream stalls: the frame store is split into four banks by row and
// column parity, so the four neighbours of a destination pixel come out of
// one read of each bank, all in the same cycle. After the edge that accepts
// a compute item, its result passes the second front stage, the queue slot,
// the bank read, the product and the sum stages; output stalls hold it back.
// A pixel must be loaded before any compute item reads it; the store has no
// clearing and holds garbage until written. Write the registers only while
// the block is idle.
module bilinear_image_scaler_top (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           opcode,
  input  wire logic [bis_pkg::COORD_W-1:0]    x_coord,
  input  wire logic [bis_pkg::COORD_W-1:0]    y_coord,
  input  wire logic [bis_pkg::CH_W-1:0]       blue_in,
  input  wire logic [bis_pkg::CH_W-1:0]       green_in,
  input  wire logic [bis_pkg::CH_W-1:0]       red_in,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [bis_pkg::CH_W-1:0]            blue_out,
  output logic [bis_pkg::CH_W-1:0]            green_out,
  output logic [bis_pkg::CH_W-1:0]            red_out,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [bis_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bis_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bis_pkg::*;

  cfg_t  cfg;
  logic  q_full;
  logic  push;
  work_t push_item;
  logic  pop;
  work_t head;
  logic  not_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_width  <= SIZE_W'(1);
      cfg.source_height <= SIZE_W'(1);
      cfg.scale_x       <= SCALE_W'(1 << FRAC_BITS);
      cfg.scale_y       <= SCALE_W'(1 << FRAC_BITS);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_SOURCE_WIDTH:  cfg.source_width  <= cfg_data[SIZE_W-1:0];
        REG_SOURCE_HEIGHT: cfg.source_height <= cfg_data[SIZE_W-1:0];
        REG_SCALE_X:       cfg.scale_x       <= cfg_data[SCALE_W-1:0];
        REG_SCALE_Y:       cfg.scale_y       <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  bis_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .opcode    (opcode),
    .x_coord   (x_coord),
    .y_coord   (y_coord),
    .blue_in   (blue_in),
    .green_in  (green_in),
    .red_in    (red_in),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  bis_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty)
  );

  bis_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .not_empty (not_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .blue_out  (blue_out),
    .green_out (green_out),
    .red_out   (red_out)
  );

endmodule
`default_nettype wire

/* src/bis_checker.sv */
`default_nettype none
`include "assert_macros.svh"
module bis_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      in_stall,
  input wire logic                      out_valid,
  input wire logic                      out_stall,
  input wire logic [bis_pkg::CH_W-1:0]  blue_out,
  input wire logic [bis_pkg::CH_W-1:0]  green_out,
  input wire logic [bis_pkg::CH_W-1:0]  red_out,
  input wire logic                      cfg_ready
);

  property p_out_hold;
    out_valid && out_stall |=> out_valid && $stable({red_out, green_out, blue_out});
  endproperty

  `BIS_ASSERT(a_out_hold, p_out_hold, "stalled result changed")
  `BIS_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid && !in_stall, "not empty after reset")
  `BIS_ASSERT_ALWAYS(a_cfg_ready, cfg_ready, "configuration port not ready")

endmodule

bind bilinear_image_scaler_top bis_checker u_checker (.*);
`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 100ps

module tb;
  import bis_pkg::*;

  class scaler_scoreboard;
    logic [PIX_W-1:0] pixels[int];
    int unsigned      width_reg = 1;
    int unsigned      height_reg = 1;
    logic [SCALE_W-1:0] scale_x = 24'h010000;
    logic [SCALE_W-1:0] scale_y = 24'h010000;
    logic [PIX_W-1:0] expected_q[$];
    int errors;
    int checked;
    int loads;

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_SOURCE_WIDTH: width_reg = d[SIZE_W-1:0];
        REG_SOURCE_HEIGHT: height_reg = d[SIZE_W-1:0];
        REG_SCALE_X: scale_x = d;
        REG_SCALE_Y: scale_y = d;
        default: ;
      endcase
    endfunction

    function int unsigned clip_size(int unsigned v, int unsigned maxv);
      if (v == 0) return 1;
      return (v > maxv) ? maxv : v;
    endfunction

    function void map_axis(int unsigned d, logic [SCALE_W-1:0] scale, int unsigned size,
                           output int unsigned i0, output int unsigned i1,
                           output longint unsigned frac);
      longint unsigned p, q, ip1, lo, last;
      p = (2 * longint'(d) + 1) * longint'(scale);
      q = (p >> 1) + (64'd1 << (FRAC_BITS - 1));
      ip1 = q >> FRAC_BITS;
      lo = (ip1 == 0) ? 0 : ip1 - 1;
      last = size - 1;
      frac = q & ((64'd1 << FRAC_BITS) - 1);
      i0 = (lo > last) ? last : lo;
      i1 = (ip1 > last) ? last : ip1;
    endfunction

    function logic [PIX_W-1:0] fetch(int unsigned col, int unsigned row);
      int a;
      a = row * MAX_WIDTH + col;
      return pixels.exists(a) ? pixels[a] : '0;
    endfunction

    function void note_input(op_t op, int unsigned x, int unsigned y,
                             logic [CH_W-1:0] b, logic [CH_W-1:0] g, logic [CH_W-1:0] r);
      int unsigned x0, x1, y0, y1;
      longint unsigned fx, fy, one, sum, v;
      longint unsigned w[4];
      logic [PIX_W-1:0] px[4];
      logic [PIX_W-1:0] res;
      if (op == OP_LOAD) begin
        loads++;
        if (x < MAX_WIDTH && y < MAX_HEIGHT) pixels[y * MAX_WIDTH + x] = {r, g, b};
        return;
      end
      map_axis(x, scale_x, clip_size(width_reg, MAX_WIDTH), x0, x1, fx);
      map_axis(y, scale_y, clip_size(height_reg, MAX_HEIGHT), y0, y1, fy);
      one = 64'd1 << FRAC_BITS;
      w[0] = (one - fx) * (one - fy);
      w[1] = fx * (one - fy);
      w[2] = (one - fx) * fy;
      w[3] = fx * fy;
      px[0] = fetch(x0, y0);
      px[1] = fetch(x1, y0);
      px[2] = fetch(x0, y1);
      px[3] = fetch(x1, y1);
      for (int c = 0; c < 3; c++) begin
        sum = 0;
        for (int k = 0; k < 4; k++) begin
          v = (px[k] >> (8 * c)) & 8'hFF;
          sum += (v * w[k] + (64'd1 << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
        end
        res[8*c +: 8] = (sum > 255) ? 8'hFF : sum[7:0];
      end
      expected_q.push_back(res);
    endfunction

    task report(string msg);
      $display("%0t ERROR: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic [CH_W-1:0] b, logic [CH_W-1:0] g, logic [CH_W-1:0] r);
      logic [PIX_W-1:0] e;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected pixel b=%0d g=%0d r=%0d", b, g, r));
        return;
      end
      e = expected_q.pop_front();
      checked++;
      if (b !== e[7:0]) report($sformatf("blue %0d, want %0d", b, e[7:0]));
      if (g !== e[15:8]) report($sformatf("green %0d, want %0d", g, e[15:8]));
      if (r !== e[23:16]) report($sformatf("red %0d, want %0d", r, e[23:16]));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic opcode = 1'b0;
  logic [COORD_W-1:0] x_coord = '0;
  logic [COORD_W-1:0] y_coord = '0;
  logic [CH_W-1:0] blue_in = '0;
  logic [CH_W-1:0] green_in = '0;
  logic [CH_W-1:0] red_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [CH_W-1:0] blue_out;
  logic [CH_W-1:0] green_out;
  logic [CH_W-1:0] red_out;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  scaler_scoreboard sb = new();
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int phases = 0;

  bilinear_image_scaler_top u_top (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(10, 80);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 9) < 3);
      default: out_stall <= ($urandom_range(0, 9) < 8);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_result(blue_out, green_out, red_out);
  end

  task send(op_t op, int unsigned x, int unsigned y, logic [PIX_W-1:0] pix);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    opcode <= op;
    x_coord <= COORD_W'(x);
    y_coord <= COORD_W'(y);
    blue_in <= pix[7:0];
    green_in <= pix[15:8];
    red_in <= pix[23:16];
    do @(posedge clk); while (in_stall);
    sb.note_input(op, x, y, pix[7:0], pix[15:8], pix[23:16]);
  endtask

  task drain();
    int n;
    in_valid <= 1'b0;
    burst_left = 0;
    n = 0;
    while (sb.expected_q.size() != 0 && n < 200000) begin
      @(posedge clk);
      n++;
    end
    repeat (20) @(posedge clk);
  endtask

  task write_cfg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, d);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task run_phase(int unsigned w, int unsigned h, logic [23:0] sx, logic [23:0] sy,
                 int ncomp, bit bright);
    int unsigned ew, eh;
    drain();
    write_cfg(REG_SOURCE_WIDTH, CFG_DATA_W'(w));
    write_cfg(REG_SOURCE_HEIGHT, CFG_DATA_W'(h));
    write_cfg(REG_SCALE_X, sx);
    write_cfg(REG_SCALE_Y, sy);
    phases++;
    ew = sb.clip_size(w, MAX_WIDTH);
    eh = sb.clip_size(h, MAX_HEIGHT);
    for (int r = 0; r < eh; r++)
      for (int c = 0; c < ew; c++)
        send(OP_LOAD, c, r, bright ? 24'hFFFFFF : 24'($urandom));
    for (int i = 0; i < ncomp; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        if (bright)
          send(OP_LOAD, $urandom_range(0, ew - 1), $urandom_range(0, eh - 1), 24'hFFFFFF);
        else
          send(OP_LOAD, $urandom_range(0, 4095), $urandom_range(0, 4095), 24'($urandom));
      end
      if ($urandom_range(0, 1) == 0)
        send(OP_COMPUTE, $urandom_range(0, 4095), $urandom_range(0, 4095), 24'($urandom));
      else
        send(OP_COMPUTE, $urandom_range(0, 2 * ew + 2), $urandom_range(0, 2 * eh + 2),
             24'($urandom));
    end
  endtask

  // oversized source on one axis; destinations from 2 up land past the far edge
  task size_limit_phase(bit on_x);
    drain();
    write_cfg(REG_SOURCE_WIDTH, on_x ? 24'd1023 : 24'd1);
    write_cfg(REG_SOURCE_HEIGHT, on_x ? 24'd1 : 24'd700);
    write_cfg(REG_SCALE_X, on_x ? 24'hFFFFFF : 24'h000001);
    write_cfg(REG_SCALE_Y, on_x ? 24'h000001 : 24'hFFFFFF);
    phases++;
    send(OP_LOAD, on_x ? MAX_WIDTH - 1 : 0, on_x ? 0 : MAX_HEIGHT - 1, 24'($urandom));
    for (int i = 0; i < 8; i++)
      send(OP_COMPUTE, $urandom_range(on_x ? 2 : 0, 4095), $urandom_range(on_x ? 0 : 2, 4095),
           24'($urandom));
  endtask

  function logic [23:0] pick_scale();
    case ($urandom_range(0, 5))
      0: return 24'h010000;
      1: return 24'hFFFFFF;
      2: return 24'($urandom_range(1, 24'h01FFFF));
      3: return 24'($urandom_range(1, 24'h00FFFF));
      4: return 24'h000000;
      default: return 24'($urandom_range(1, 24'hFFFFFF));
    endcase
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send(OP_LOAD, 0, 0, 24'hFF00FF);
    send(OP_COMPUTE, 0, 0, 24'h000000);
    send(OP_COMPUTE, 4095, 4095, 24'hFFFFFF);
    send(OP_COMPUTE, 0, 4095, 24'h123456);
    send(OP_LOAD, MAX_WIDTH, 5, 24'h00FF00);
    send(OP_LOAD, 7, MAX_HEIGHT, 24'h00FF00);
    send(OP_LOAD, 4095, 4095, 24'h00FF00);
    send(OP_COMPUTE, 4095, 0, 24'h000000);
    send(OP_LOAD, 0, 0, 24'h00FF00);
    send(OP_COMPUTE, 1, 1, 24'h000000);

    run_phase(0, 0, 24'h000000, 24'h000000, 10, 1'b0);
    size_limit_phase(1'b1);
    size_limit_phase(1'b0);
    run_phase(2, 2, 24'h008000, 24'h008000, 25, 1'b1);
    for (int p = 0; p < 8; p++)
      run_phase($urandom_range(1, 8), $urandom_range(1, 8), pick_scale(), pick_scale(),
                36, ($urandom_range(0, 4) == 0));
    drain();

    $display("Covered %0d config phases: %0d loads, %0d pixels checked, %0d errors.",
             phases, sb.loads, sb.checked, sb.errors);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      if (sb.expected_q.size() != 0)
        $display("%0d expected pixels never arrived", sb.expected_q.size());
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Timeout");
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/bis_pkg.sv
src/bis_ram.sv
src/bis_front.sv
src/bis_queue.sv
src/bis_back.sv
src/bilinear_image_scaler_top.sv
src/bis_checker.sv
tb/sv/tb.sv
